FILE: hw/rtl/cbfir_pkg.sv
`timescale 1ns / 1ps

package cbfir_pkg;

  // Filter geometry
  localparam int MAX_TAPS = 64;
  localparam int TAP_W    = $clog2(MAX_TAPS);        // delay line / coefficient address
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);    // holds a tap count up to MAX_TAPS

  // Field widths
  localparam int TC_W     = 7;                       // tap_count register
  localparam int TIDX_W   = 6;                       // tap_index field
  localparam int VALUE_W  = 16;                      // sample and coefficient
  localparam int PROD_W   = 2 * VALUE_W;
  localparam int ACC_W    = PROD_W + TAP_W;          // exact sum of MAX_TAPS products
  localparam int FRAC_W   = 15;                      // Q1.15 coefficient scaling

  localparam logic [TC_W-1:0] TAP_COUNT_RST = TC_W'(10);

  // Input commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load_sample;   // store sample, set up a new pass
    logic write_coef;    // store one coefficient
    logic issue;         // read one tap pair and advance the pointers
    logic emit;          // load the result into the output register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_tap;      // current read is the final tap
    logic pipe_busy;     // reads or products still in flight
    logic out_free;      // output register can take a result this cycle
  } ctrl_sts_t;

  // Taps in use: zero acts as one, anything above MAX_TAPS acts as MAX_TAPS
  function automatic logic [CNT_W-1:0] taps_in_use(input logic [TC_W-1:0] tc);
    logic [CNT_W-1:0] n;
    if (tc == '0) begin
      n = CNT_W'(1);
    end else if (32'(tc) > 32'(MAX_TAPS)) begin
      n = CNT_W'(MAX_TAPS);
    end else begin
      n = CNT_W'(tc);
    end
    return n;
  endfunction

endpackage

FILE: hw/rtl/cbfir_in_if.sv
`timescale 1ns / 1ps

interface cbfir_in_if
  import cbfir_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [TIDX_W-1:0]         tap_index;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, cmd, tap_index, value, input ready);
  modport sink   (input valid, cmd, tap_index, value, output ready);
endinterface

FILE: hw/rtl/cbfir_out_if.sv
`timescale 1ns / 1ps

interface cbfir_out_if
  import cbfir_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] filtered_sample;
  logic                      saturated;

  modport source (output valid, filtered_sample, saturated, input ready);
  modport sink   (input valid, filtered_sample, saturated, output ready);
endinterface

FILE: hw/rtl/cbfir_cfg_if.sv
`timescale 1ns / 1ps

interface cbfir_cfg_if
  import cbfir_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic [TC_W-1:0] tap_count;

  modport source (output valid, tap_count, input ready);
  modport sink   (input valid, tap_count, output ready);
endinterface

FILE: hw/rtl/cbfir_ctrl.sv
`timescale 1ns / 1ps

module cbfir_ctrl
  import cbfir_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_cmd_i,
  output logic      in_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   in_xfer;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  // Decode commands and next state
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_cmd_i == CMD_COEF) begin
            cmd_o.write_coef = 1'b1;
          end else begin
            cmd_o.load_sample = 1'b1;
            state_d           = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_tap) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/cbfir_dpath.sv
`timescale 1ns / 1ps

module cbfir_dpath
  import cbfir_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ctrl_cmd_t                 cmd_i,
  output ctrl_sts_t                 sts_o,
  input  logic                      cfg_we_i,
  input  logic [TC_W-1:0]           cfg_tap_count_i,
  input  logic [TIDX_W-1:0]         tap_index_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [VALUE_W-1:0] filtered_sample_o,
  output logic                      saturated_o
);

  // Storage
  logic signed [VALUE_W-1:0] dl_mem [MAX_TAPS];
  logic signed [VALUE_W-1:0] cf_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]       dl_valid_q;

  // Control registers
  logic [TC_W-1:0]  tap_count_q;
  logic [TAP_W-1:0] wp_q, wp_d;
  logic [TAP_W-1:0] tap_q, pos_q;
  logic             rd_v_q, mul_v_q, out_valid_q;

  // Pipeline payload
  logic signed [VALUE_W-1:0] rd_cf_q, rd_dl_q;
  logic                      rd_dv_q;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [VALUE_W-1:0] out_data_q;
  logic                      out_sat_q;

  logic [CNT_W-1:0]          n_taps;
  logic [TAP_W-1:0]          wp_eff;
  logic [CNT_W-1:0]          pos_inc;
  logic [TAP_W-1:0]          pos_nxt;
  logic signed [VALUE_W-1:0] dl_op;
  logic                      res_sat;
  logic signed [VALUE_W-1:0] res_val;
  logic                      coef_in_range;

  assign n_taps = taps_in_use(tap_count_q);

  // Write position falls back to zero when the tap count shrank below it
  assign wp_eff = (CNT_W'(wp_q) >= n_taps) ? '0 : wp_q;
  // Next sample lands one place before this one, wrapping to the top tap
  assign wp_d   = (wp_eff == '0) ? TAP_W'(n_taps - CNT_W'(1)) : wp_eff - TAP_W'(1);

  // Circular read pointer
  assign pos_inc = CNT_W'(pos_q) + CNT_W'(1);
  assign pos_nxt = (pos_inc >= n_taps) ? '0 : TAP_W'(pos_inc);

  assign coef_in_range = (32'(tap_index_i) < 32'(MAX_TAPS));

  // Status to the controller
  assign sts_o.last_tap  = (CNT_W'(tap_q) == (n_taps - CNT_W'(1)));
  assign sts_o.pipe_busy = rd_v_q || mul_v_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_COUNT_RST;
      wp_q        <= '0;
      dl_valid_q  <= '0;
      tap_q       <= '0;
      pos_q       <= '0;
      rd_v_q      <= 1'b0;
      mul_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tap_count_q <= cfg_tap_count_i;
        wp_q        <= '0;
      end
      if (cmd_i.load_sample) begin
        dl_valid_q[wp_eff] <= 1'b1;
        wp_q               <= wp_d;
        tap_q              <= '0;
        pos_q              <= wp_eff;
      end else if (cmd_i.issue) begin
        tap_q <= tap_q + TAP_W'(1);
        pos_q <= pos_nxt;
      end
      rd_v_q  <= cmd_i.issue;
      mul_v_q <= rd_v_q;
      // Set on a new result, drop once the sink takes the transaction
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Delay line memory: write the new sample, read one tap a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      dl_mem[wp_eff] <= value_i;
    end
    if (cmd_i.issue) begin
      rd_dl_q <= dl_mem[pos_q];
      rd_dv_q <= dl_valid_q[pos_q];
    end
  end

  // Coefficient memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_coef && coef_in_range) begin
      cf_mem[TAP_W'(tap_index_i)] <= value_i;
    end
    if (cmd_i.issue) begin
      rd_cf_q <= cf_mem[tap_q];
    end
  end

  // Multiply and accumulate; never-written delay entries read as zero
  assign dl_op  = rd_dv_q ? rd_dl_q : '0;
  assign prod_d = rd_cf_q * dl_op;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load_sample) begin
      acc_q <= '0;
    end else if (mul_v_q) begin
      acc_q <= acc_q + {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  // Shift down by 15 and clamp: out of range when the bits above the result
  // are not all copies of its sign
  assign res_sat = !((&acc_q[ACC_W-1:FRAC_W+VALUE_W-1]) ||
                     !(|acc_q[ACC_W-1:FRAC_W+VALUE_W-1]));
  always_comb begin
    if (!res_sat) begin
      res_val = acc_q[FRAC_W+VALUE_W-1:FRAC_W];
    end else if (acc_q[ACC_W-1]) begin
      res_val = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      res_val = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= res_val;
      out_sat_q  <= res_sat;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign filtered_sample_o = out_data_q;
  assign saturated_o       = out_sat_q;

endmodule

FILE: hw/rtl/circular_buffer_fir_filter_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload                             Handshake
// in_i      sink       cmd, tap_index, value               valid / ready
// out_o     source     filtered_sample, saturated          valid / ready
// cfg_i     sink       tap_count                           valid / ready (idle, no input offered)
//
// A coefficient is written when its transaction is accepted. A sample passes
// through the accept, a run in which one shared multiply-accumulate reads one
// delay/coefficient pair per cycle, the pipeline drain and the load of the
// result.
// Reset sets tap_count to 10 and clears the delay line through per-entry valid
// bits at once. A stalled output holds the finished result; the next input
// transaction is still taken, and its result waits until the register frees.

module circular_buffer_fir_filter_core
  import cbfir_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  cbfir_in_if.sink     in_i,
  cbfir_out_if.source  out_o,
  cbfir_cfg_if.sink    cfg_i
);

  ctrl_cmd_t ctrl_cmd;
  ctrl_sts_t ctrl_sts;
  logic      cfg_we;

  // Take configuration only while the controller is idle and no input is offered
  assign cfg_i.ready = in_i.ready && !in_i.valid;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  cbfir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_i.ready),
    .sts_i      (ctrl_sts),
    .cmd_o      (ctrl_cmd)
  );

  cbfir_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (ctrl_cmd),
    .sts_o             (ctrl_sts),
    .cfg_we_i          (cfg_we),
    .cfg_tap_count_i   (cfg_i.tap_count),
    .tap_index_i       (in_i.tap_index),
    .value_i           (in_i.value),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .filtered_sample_o (out_o.filtered_sample),
    .saturated_o       (out_o.saturated)
  );

endmodule
